// ----- hdl/lapedge_pkg.sv -----
package lapedge_pkg;

	// default geometry limits
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	// register field widths
	localparam int THRESH_W     = 8;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 2;
	localparam int PIXEL_W      = 8;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_EDGE_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT   = 2'd2;

	// register reset values
	localparam logic [THRESH_W-1:0]     RST_EDGE_THRESHOLD = 8'd0;
	localparam logic [WIDTH_REG_W-1:0]  RST_FRAME_WIDTH    = 11'd1024;
	localparam logic [HEIGHT_REG_W-1:0] RST_FRAME_HEIGHT   = 13'd4096;

	// smallest frame dimension
	localparam int MIN_DIM = 2;

	// item commands
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// result codes
	localparam logic [PIXEL_W-1:0] EDGE_ON  = 8'd255;
	localparam logic [PIXEL_W-1:0] EDGE_OFF = 8'd0;
	localparam logic [PIXEL_W-1:0] RESP_MAX = 8'd255;

endpackage

// ----- hdl/laplacian_edge_threshold.sv -----
// 3x3 Laplacian edge detector with threshold over a raster stream of gray pixels.
// Input channel (in_valid/in_ready, command, gray_pixel): one pixel or flush item per
// transfer. Output channel (out_valid/out_ready, edge_value, frame_end): one edge flag
// per transfer, frame_end on the bottom-right pixel.
// Throughput: one item per clock while the receiver takes results. Two line stores, each
// with one write and two reads per cycle, are read ahead into registers for the next
// column; a write to the same entry in the previous cycle is forwarded. Results lag one
// row: pixels of row r give the results of row r-1, and after the last pixel one flush
// item per column empties the last row. A result is in the output register in the cycle
// after its item's transfer. Row zero pixels and items of the wrong kind (flush while
// taking pixels, pixel while flushing) give no result. When the receiver stalls, the
// result waits in the output register and in_ready drops until it is taken.
// Reset: registers return to threshold 0, width 1024, height 4096; position to the top
// left of a frame. The line stores are not cleared and need no clearing pass. The user
// must write configuration (cfg_write, cfg_index, cfg_data) only while idle; unchecked.
module laplacian_edge_threshold #(
	parameter int MAX_WIDTH  = lapedge_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = lapedge_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_write,
	input  logic [lapedge_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [lapedge_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input items
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 command,
	input  logic [lapedge_pkg::PIXEL_W-1:0]      gray_pixel,
	// results
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [lapedge_pkg::PIXEL_W-1:0]      edge_value,
	output logic                                 frame_end
);

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WCW = $clog2(MAX_WIDTH + 1);
	localparam int HCW = $clog2(MAX_HEIGHT + 1);
	localparam int WW  = (WCW > lapedge_pkg::WIDTH_REG_W) ? WCW : lapedge_pkg::WIDTH_REG_W;
	localparam int HW  = (HCW > lapedge_pkg::HEIGHT_REG_W) ? HCW : lapedge_pkg::HEIGHT_REG_W;
	localparam int PW  = lapedge_pkg::PIXEL_W;
	localparam int SW  = PW + 2;

	function automatic logic [WW-1:0] eff_width(input logic [lapedge_pkg::WIDTH_REG_W-1:0] v);
		logic [WW-1:0] x;
		x = WW'(v);
		if (x < WW'(lapedge_pkg::MIN_DIM)) x = WW'(lapedge_pkg::MIN_DIM);
		else if (x > WW'(MAX_WIDTH)) x = WW'(MAX_WIDTH);
		return x;
	endfunction

	function automatic logic [HW-1:0] eff_height(input logic [lapedge_pkg::HEIGHT_REG_W-1:0] v);
		logic [HW-1:0] x;
		x = HW'(v);
		if (x < HW'(lapedge_pkg::MIN_DIM)) x = HW'(lapedge_pkg::MIN_DIM);
		else if (x > HW'(MAX_HEIGHT)) x = HW'(MAX_HEIGHT);
		return x;
	endfunction

	// configuration registers
	logic [lapedge_pkg::THRESH_W-1:0]     edge_threshold_q;
	logic [lapedge_pkg::WIDTH_REG_W-1:0]  frame_width_q;
	logic [lapedge_pkg::HEIGHT_REG_W-1:0] frame_height_q;

	// position state
	logic [AW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          flush_q;

	// line stores and their read registers
	logic [PW-1:0] older_mem [MAX_WIDTH];
	logic [PW-1:0] newer_mem [MAX_WIDTH];
	logic [PW-1:0] older_rd_c_q, older_rd_l_q, newer_rd_c_q, newer_rd_r_q;
	logic          older_hit_c_q, older_hit_l_q, newer_hit_c_q, newer_hit_r_q;
	logic [PW-1:0] older_wdata_q, newer_wdata_q;

	// output register
	logic          out_valid_q;
	logic [PW-1:0] edge_value_q;
	logic          frame_end_q;

	logic [WW-1:0] w_eff, w_next;
	logic [HW-1:0] h_eff;
	logic [AW-1:0] col_c, col_next, rd_c, rd_l, rd_r;
	logic          accept, act_pix, act_flush, act_result, col_last;
	logic          older_we, newer_we;
	logic [PW-1:0] centre, up_px, down_px, left_px, right_px;
	logic [SW-1:0] pos_sum, neg_sum, diff;
	logic [PW-1:0] resp;
	logic          is_edge;

	// handshake and item decode
	assign in_ready   = ~out_valid_q | out_ready;
	assign accept     = in_valid & in_ready;
	assign act_pix    = accept & (command == lapedge_pkg::CMD_PIXEL) & ~flush_q;
	assign act_flush  = accept & (command == lapedge_pkg::CMD_FLUSH) & flush_q;
	assign act_result = (act_pix & (row_q != '0)) | act_flush;

	// effective geometry, and the width as it stands after a write in this cycle
	assign w_eff = eff_width(frame_width_q);
	assign h_eff = eff_height(frame_height_q);
	assign w_next = (cfg_write && cfg_index == lapedge_pkg::REG_FRAME_WIDTH)
		? eff_width(cfg_data[lapedge_pkg::WIDTH_REG_W-1:0]) : w_eff;

	// column of the current item, pulled in to the last column if the width shrank
	assign col_c    = (WW'(col_q) >= w_eff) ? AW'(w_eff - WW'(1)) : col_q;
	assign col_last = (WW'(col_c) + WW'(1)) >= w_eff;

	// next column and read addresses for the following item
	always_comb begin
		col_next = col_q;
		if (act_pix || act_flush) begin
			col_next = col_last ? '0 : AW'(WW'(col_c) + WW'(1));
		end
	end

	always_comb begin
		rd_c = (WW'(col_next) >= w_next) ? AW'(w_next - WW'(1)) : col_next;
		rd_l = rd_c - AW'(1);
		rd_r = rd_c + AW'(1);
	end

	// store writes
	assign newer_we = act_pix;
	assign older_we = (act_pix & (row_q != '0)) | act_flush;

	// older row store: read centre column and left column
	always_ff @(posedge clk) begin
		if (older_we) begin
			older_mem[col_c] <= centre;
		end
		older_rd_c_q <= older_mem[rd_c];
		older_rd_l_q <= older_mem[rd_l];
	end

	// newer row store: read centre column and right column
	always_ff @(posedge clk) begin
		if (newer_we) begin
			newer_mem[col_c] <= gray_pixel;
		end
		newer_rd_c_q <= newer_mem[rd_c];
		newer_rd_r_q <= newer_mem[rd_r];
	end

	// forwarding of a write that the reads of the same edge missed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_hit_c_q <= 1'b0;
			older_hit_l_q <= 1'b0;
			newer_hit_c_q <= 1'b0;
			newer_hit_r_q <= 1'b0;
		end else begin
			older_hit_c_q <= older_we && (col_c == rd_c);
			older_hit_l_q <= older_we && (col_c == rd_l);
			newer_hit_c_q <= newer_we && (col_c == rd_c);
			newer_hit_r_q <= newer_we && (col_c == rd_r);
		end
	end

	always_ff @(posedge clk) begin
		older_wdata_q <= centre;
		newer_wdata_q <= gray_pixel;
	end

	// stencil operands
	always_comb begin
		centre   = newer_hit_c_q ? newer_wdata_q : newer_rd_c_q;
		up_px    = (flush_q || row_q > RW'(1))
			? (older_hit_c_q ? older_wdata_q : older_rd_c_q) : centre;
		left_px  = (col_c != '0) ? (older_hit_l_q ? older_wdata_q : older_rd_l_q) : centre;
		right_px = col_last ? centre : (newer_hit_r_q ? newer_wdata_q : newer_rd_r_q);
		down_px  = flush_q ? centre : gray_pixel;
	end

	// response: 4*centre minus neighbours, clamped, then thresholded
	always_comb begin
		pos_sum = {centre, 2'b00};
		neg_sum = SW'(up_px) + SW'(down_px) + SW'(left_px) + SW'(right_px);
		diff    = pos_sum - neg_sum;
		if (pos_sum <= neg_sum) resp = '0;
		else if (diff > SW'(lapedge_pkg::RESP_MAX)) resp = lapedge_pkg::RESP_MAX;
		else resp = diff[PW-1:0];
		is_edge = resp > edge_threshold_q;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_threshold_q <= lapedge_pkg::RST_EDGE_THRESHOLD;
			frame_width_q    <= lapedge_pkg::RST_FRAME_WIDTH;
			frame_height_q   <= lapedge_pkg::RST_FRAME_HEIGHT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				lapedge_pkg::REG_EDGE_THRESHOLD: begin
					edge_threshold_q <= cfg_data[lapedge_pkg::THRESH_W-1:0];
				end
				lapedge_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data[lapedge_pkg::WIDTH_REG_W-1:0];
				end
				lapedge_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[lapedge_pkg::HEIGHT_REG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// raster position and flush phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			flush_q <= 1'b0;
		end else begin
			col_q <= col_next;
			if (act_pix && col_last) begin
				if ((HW'(row_q) + HW'(1)) >= h_eff) begin
					row_q   <= '0;
					flush_q <= 1'b1;
				end else begin
					row_q <= row_q + RW'(1);
				end
			end else if (act_flush && col_last) begin
				row_q   <= '0;
				flush_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (act_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (act_result) begin
			edge_value_q <= is_edge ? lapedge_pkg::EDGE_ON : lapedge_pkg::EDGE_OFF;
			frame_end_q  <= act_flush & col_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign edge_value = edge_value_q;
	assign frame_end  = frame_end_q;

	// checks
	a_flush_row: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> (row_q == '0))
		else $error("flush phase with non-zero row");

	a_flush_result: assert property (@(posedge clk) disable iff (!arst_n)
		act_flush |=> out_valid_q)
		else $error("flush item gave no result");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(act_flush && col_last) |=> (!flush_q && col_q == '0 && frame_end_q))
		else $error("frame end did not return to the top left");

endmodule
